// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/srpf_pkg.sv -----
// ----------------------------------------------------------------------------
// srpf_pkg
// Types and codes shared by the sized resource pool.
// ----------------------------------------------------------------------------
`default_nettype none

package srpf_pkg;

   localparam int DimW    = 15;
   localparam int FiltW   = 16;
   localparam int HandleW = 32;
   localparam int StatusW = 3;
   localparam int CountW  = 6;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_STORED  = 3'd2,
      ST_FULL    = 3'd3,
      ST_CLEARED = 3'd4,
      ST_UNUSED5 = 3'd5,
      ST_UNUSED6 = 3'd6,
      ST_UNUSED7 = 3'd7
   } status_type;

   // classified command handed from the front to the back
   typedef struct packed {
      opcode_type          op;
      logic                use_height;  // get walks the height order
      logic                skip;        // get forced to miss
      logic [DimW-1:0]     width;
      logic [DimW-1:0]     height;
      logic [FiltW-1:0]    fmin;
      logic [FiltW-1:0]    fmag;
      logic [HandleW-1:0]  handle;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK_W,
      BK_WALK_H,
      BK_SEARCH,
      BK_REMOVE,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sized_resource_pool_fit.sv -----
// ----------------------------------------------------------------------------
// sized_resource_pool_fit
// Pool of free sized buffers with first-fit lookup in two sorted orders.
// ----------------------------------------------------------------------------
// Usage: req_* carries one transaction (put, get or clear) on valid/ready;
// rsp_* returns exactly one result per transaction on valid/ready.
// A front stage classifies requests into a two-deep queue; the back end walks
// the size-sorted lists one position per cycle.
// Steps: clear, rejected put, forced miss and unused opcode go from idle
// straight to the done state; a put walks the width list and then the height
// list to its insert positions; a get walks one list up to the first fit and
// then removes the entry, a miss walks all held entries. The lists are walked
// through a single port. One transaction is in the back end at a time.
// Reset empties the pool and the queue. While rsp_ready is low the result is
// held and the queue keeps taking up to two requests.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sized_resource_pool_fit #(
   parameter int POOL_DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [14:0]                   req_width,
   input  wire logic [14:0]                   req_height,
   input  wire logic [15:0]                   req_min_filter_code,
   input  wire logic [15:0]                   req_mag_filter_code,
   input  wire logic                          req_force_new,
   input  wire logic [31:0]                   req_entry_handle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [31:0]                        rsp_out_handle,
   output logic [5:0]                         rsp_pool_count
);

   srpf_pkg::cmd_type in_cmd, q_cmd;
   logic              q_valid, q_ready;

   always_comb begin
      in_cmd            = '0;
      in_cmd.op         = srpf_pkg::opcode_type'(req_opcode);
      in_cmd.skip       = req_force_new;
      in_cmd.width      = req_width;
      in_cmd.height     = req_height;
      in_cmd.fmin       = req_min_filter_code;
      in_cmd.fmag       = req_mag_filter_code;
      in_cmd.handle     = req_entry_handle;
   end

   srpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_cmd   (in_cmd),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd)
   );

   srpf_back #(.PoolDepth(POOL_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_handle (rsp_out_handle),
      .rsp_count  (rsp_pool_count)
   );

   `ASSERT_IMPL(a_count_range, clock, reset, rsp_valid,
      int'(rsp_pool_count) <= POOL_DEPTH, "pool count beyond depth")
   `ASSERT_IMPL(a_clear_zero, clock, reset,
      rsp_valid && rsp_status == srpf_pkg::ST_CLEARED,
      rsp_pool_count == 6'd0, "clear left entries")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status), "result dropped under stall")

endmodule

`default_nettype wire

// ----- hw/rtl/srpf_front.sv -----
// ----------------------------------------------------------------------------
// srpf_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module srpf_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire srpf_pkg::cmd_type    in_cmd,
   output logic                      q_valid,
   input  wire logic                 q_ready,
   output srpf_pkg::cmd_type         q_cmd
);

   // two-entry queue
   srpf_pkg::cmd_type mem_ff [2];
   srpf_pkg::cmd_type cls;
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   always_comb begin
      cls            = in_cmd;
      cls.use_height = (in_cmd.width < in_cmd.height);
      cls.skip       = (in_cmd.op == srpf_pkg::OP_GET) && in_cmd.skip;
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cmd    = mem_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= cls;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/srpf_back.sv -----
// ----------------------------------------------------------------------------
// srpf_back
// Walks the sorted lists one position per cycle and updates the pool.
// ----------------------------------------------------------------------------
`default_nettype none

module srpf_back #(
   parameter int PoolDepth = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   output logic                               q_ready,
   input  wire srpf_pkg::cmd_type             q_cmd,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [srpf_pkg::StatusW-1:0]       rsp_status,
   output logic [srpf_pkg::HandleW-1:0]       rsp_handle,
   output logic [srpf_pkg::CountW-1:0]        rsp_count
);

   localparam int SW = (PoolDepth > 1) ? $clog2(PoolDepth) : 1;
   localparam int CW = $clog2(PoolDepth + 1);

   // slot data, held in registers read at the slot named by the walk
   logic [srpf_pkg::DimW-1:0]    sw_ff [PoolDepth];
   logic [srpf_pkg::DimW-1:0]    sh_ff [PoolDepth];
   logic [srpf_pkg::FiltW-1:0]   sfmin_ff [PoolDepth];
   logic [srpf_pkg::FiltW-1:0]   sfmag_ff [PoolDepth];
   logic [srpf_pkg::HandleW-1:0] shd_ff [PoolDepth];
   logic [PoolDepth-1:0]         valid_ff;
   logic [SW-1:0]                wlist_ff [PoolDepth];
   logic [SW-1:0]                hlist_ff [PoolDepth];
   logic [CW-1:0]                held_ff;

   srpf_pkg::back_state_type state_ff, state_in;
   srpf_pkg::cmd_type        cmd_ff;
   logic [CW-1:0]            pos_ff;
   logic [CW-1:0]            wpos_ff;
   logic [SW-1:0]            slot_ff;    // free slot on put, found slot on get
   logic                     out_full_ff;
   logic [srpf_pkg::StatusW-1:0] st_ff;
   logic [srpf_pkg::HandleW-1:0] hd_ff;

   logic [SW-1:0] free_slot;
   logic          have_free;
   logic [SW-1:0] cur_slot;
   logic          pos_end;
   logic          after_w, after_h, fits;
   logic [SW-1:0] pos_idx;

   // lowest free slot
   always_comb begin
      free_slot = '0;
      have_free = 1'b0;
      for (int i = PoolDepth - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SW'(i);
            have_free = 1'b1;
         end
      end
   end

   assign pos_end = (pos_ff >= held_ff);
   assign pos_idx = pos_ff[SW-1:0];
   assign cur_slot = (state_ff == srpf_pkg::BK_WALK_H ||
                      (state_ff == srpf_pkg::BK_SEARCH && cmd_ff.use_height))
                     ? hlist_ff[pos_idx] : wlist_ff[pos_idx];

   assign after_w = (sw_ff[cur_slot] > cmd_ff.width) ||
                    (sw_ff[cur_slot] == cmd_ff.width && sh_ff[cur_slot] > cmd_ff.height);
   assign after_h = (sh_ff[cur_slot] > cmd_ff.height) ||
                    (sh_ff[cur_slot] == cmd_ff.height && sw_ff[cur_slot] > cmd_ff.width);
   assign fits    = valid_ff[cur_slot] && (sw_ff[cur_slot] >= cmd_ff.width) &&
                    (sh_ff[cur_slot] >= cmd_ff.height) &&
                    (sfmin_ff[cur_slot] == cmd_ff.fmin) &&
                    (sfmag_ff[cur_slot] == cmd_ff.fmag);

   assign q_ready    = (state_ff == srpf_pkg::BK_IDLE);
   assign rsp_valid  = (state_ff == srpf_pkg::BK_DONE);
   assign rsp_status = st_ff;
   assign rsp_handle = hd_ff;
   assign rsp_count  = srpf_pkg::CountW'(held_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srpf_pkg::BK_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.op)
                  srpf_pkg::OP_PUT:
                     state_in = (held_ff >= CW'(PoolDepth) || !have_free)
                                ? srpf_pkg::BK_DONE : srpf_pkg::BK_WALK_W;
                  srpf_pkg::OP_GET:
                     state_in = q_cmd.skip ? srpf_pkg::BK_DONE : srpf_pkg::BK_SEARCH;
                  default: state_in = srpf_pkg::BK_DONE;
               endcase
            end
         end
         srpf_pkg::BK_WALK_W:
            if (pos_end || after_w) state_in = srpf_pkg::BK_WALK_H;
         srpf_pkg::BK_WALK_H:
            if (pos_end || after_h) state_in = srpf_pkg::BK_DONE;
         srpf_pkg::BK_SEARCH: begin
            if (pos_end)   state_in = srpf_pkg::BK_DONE;
            else if (fits) state_in = srpf_pkg::BK_REMOVE;
         end
         srpf_pkg::BK_REMOVE: state_in = srpf_pkg::BK_DONE;
         srpf_pkg::BK_DONE:
            if (rsp_ready) state_in = srpf_pkg::BK_IDLE;
         default: state_in = srpf_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srpf_pkg::BK_IDLE;
         valid_ff <= '0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            srpf_pkg::BK_IDLE:
               if (q_valid && q_cmd.op == srpf_pkg::OP_CLEAR) begin
                  valid_ff <= '0;
                  held_ff  <= '0;
               end
            srpf_pkg::BK_WALK_H:
               if (pos_end || after_h) begin
                  valid_ff[slot_ff] <= 1'b1;
                  held_ff <= held_ff + 1'b1;
               end
            srpf_pkg::BK_REMOVE: begin
               valid_ff[slot_ff] <= 1'b0;
               held_ff <= held_ff - 1'b1;
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         srpf_pkg::BK_IDLE: begin
            cmd_ff  <= q_cmd;
            pos_ff  <= '0;
            slot_ff <= free_slot;
            hd_ff   <= '0;
            st_ff   <= srpf_pkg::ST_MISS;
            if (q_valid) begin
               case (q_cmd.op)
                  srpf_pkg::OP_PUT:
                     if (held_ff >= CW'(PoolDepth) || !have_free) begin
                        st_ff <= srpf_pkg::ST_FULL;
                        hd_ff <= q_cmd.handle;
                     end
                  srpf_pkg::OP_CLEAR: st_ff <= srpf_pkg::ST_CLEARED;
                  default: ;
               endcase
            end
         end
         srpf_pkg::BK_WALK_W: begin
            if (pos_end || after_w) begin
               wpos_ff <= pos_ff;
               pos_ff  <= '0;
               sw_ff[slot_ff]    <= cmd_ff.width;
               sh_ff[slot_ff]    <= cmd_ff.height;
               sfmin_ff[slot_ff] <= cmd_ff.fmin;
               sfmag_ff[slot_ff] <= cmd_ff.fmag;
               shd_ff[slot_ff]   <= cmd_ff.handle;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         srpf_pkg::BK_WALK_H: begin
            if (pos_end || after_h) begin
               // shift both lists open and drop the new slot in
               for (int i = 0; i < PoolDepth; i++) begin
                  if (CW'(i) == wpos_ff)
                     wlist_ff[i] <= slot_ff;
                  else if (CW'(i) > wpos_ff && CW'(i) <= held_ff && i > 0)
                     wlist_ff[i] <= wlist_ff[(i > 0) ? i - 1 : 0];
                  if (CW'(i) == pos_ff)
                     hlist_ff[i] <= slot_ff;
                  else if (CW'(i) > pos_ff && CW'(i) <= held_ff && i > 0)
                     hlist_ff[i] <= hlist_ff[(i > 0) ? i - 1 : 0];
               end
               st_ff <= srpf_pkg::ST_STORED;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         srpf_pkg::BK_SEARCH: begin
            if (!pos_end && fits) begin
               slot_ff <= cur_slot;
               hd_ff   <= shd_ff[cur_slot];
               st_ff   <= srpf_pkg::ST_HIT;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         srpf_pkg::BK_REMOVE: begin
            // close the gap left by the slot in both lists
            for (int i = 0; i < PoolDepth; i++) begin
               logic [PoolDepth-1:0] wb, hb;
               wb = '0;
               hb = '0;
               for (int j = 0; j <= i; j++) begin
                  wb[j] = (wlist_ff[j] == slot_ff);
                  hb[j] = (hlist_ff[j] == slot_ff);
               end
               if ((|wb) && i + 1 < PoolDepth)
                  wlist_ff[i] <= wlist_ff[(i + 1 < PoolDepth) ? i + 1 : i];
               if ((|hb) && i + 1 < PoolDepth)
                  hlist_ff[i] <= hlist_ff[(i + 1 < PoolDepth) ? i + 1 : i];
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- dv/tb_sized_resource_pool_fit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sized_resource_pool_fit
// Runs put, get and clear traffic through the sized buffer pool and checks
// every result against a model of the pool kept in the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sized_resource_pool_fit;

   localparam int Depth    = 32;
   localparam int WatchMax = 20000;

   typedef struct packed {
      srpf_pkg::opcode_type op;
      logic [14:0] w;
      logic [14:0] h;
      logic [15:0] fmin;
      logic [15:0] fmag;
      logic        force_new;
      logic [31:0] handle;
   } pool_req_type;

   typedef struct packed {
      srpf_pkg::status_type status;
      logic [31:0] handle;
      logic [5:0]  count;
   } pool_rsp_type;

   typedef struct {
      pool_req_type req;
      logic         typed;
      pool_rsp_type rsp;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = '0;
   logic [14:0] req_width = '0;
   logic [14:0] req_height = '0;
   logic [15:0] req_min_filter_code = '0;
   logic [15:0] req_mag_filter_code = '0;
   logic req_force_new = 1'b0;
   logic [31:0] req_entry_handle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [31:0] rsp_out_handle;
   logic [5:0] rsp_pool_count;

   always #5 clock = ~clock;

   sized_resource_pool_fit #(.POOL_DEPTH(Depth)) DUT (.*);

   // pool model
   logic        m_valid [Depth];
   logic [14:0] m_w [Depth];
   logic [14:0] m_h [Depth];
   logic [15:0] m_fmin [Depth];
   logic [15:0] m_fmag [Depth];
   logic [31:0] m_handle [Depth];
   int          width_order[$];
   int          height_order[$];

   pool_rsp_type expected_rsps[$];
   int  mismatches = 0;
   int  hits = 0, misses = 0, fulls = 0, stores = 0;
   int  send_idle = 37, recv_idle = 57;
   int  watchdog = 0;
   logic timed_out = 1'b0;

   function automatic pool_rsp_type pool_apply(pool_req_type r);
      pool_rsp_type o;
      int slot, pos, s;
      o.status = srpf_pkg::ST_MISS;
      o.handle = '0;
      if (r.op == srpf_pkg::OP_PUT) begin
         slot = 0;
         while (slot < Depth && m_valid[slot]) slot++;
         if (width_order.size() >= Depth || slot >= Depth) begin
            o.status = srpf_pkg::ST_FULL;
            o.handle = r.handle;
         end else begin
            m_valid[slot] = 1'b1;
            m_w[slot] = r.w;  m_h[slot] = r.h;
            m_fmin[slot] = r.fmin;  m_fmag[slot] = r.fmag;
            m_handle[slot] = r.handle;
            for (pos = 0; pos < width_order.size(); pos++) begin
               s = width_order[pos];
               if (m_w[s] > r.w || (m_w[s] == r.w && m_h[s] > r.h)) break;
            end
            width_order.insert(pos, slot);
            for (pos = 0; pos < height_order.size(); pos++) begin
               s = height_order[pos];
               if (m_h[s] > r.h || (m_h[s] == r.h && m_w[s] > r.w)) break;
            end
            height_order.insert(pos, slot);
            o.status = srpf_pkg::ST_STORED;
         end
      end else if (r.op == srpf_pkg::OP_GET) begin
         if (!r.force_new) begin
            for (pos = 0; pos < width_order.size(); pos++) begin
               s = (r.w >= r.h) ? width_order[pos] : height_order[pos];
               if (m_w[s] >= r.w && m_h[s] >= r.h && m_fmin[s] == r.fmin &&
                   m_fmag[s] == r.fmag) begin
                  o.handle = m_handle[s];
                  o.status = srpf_pkg::ST_HIT;
                  m_valid[s] = 1'b0;
                  foreach (width_order[i])
                     if (width_order[i] == s) begin width_order.delete(i); break; end
                  foreach (height_order[i])
                     if (height_order[i] == s) begin height_order.delete(i); break; end
                  break;
               end
            end
         end
      end else if (r.op == srpf_pkg::OP_CLEAR) begin
         foreach (m_valid[i]) m_valid[i] = 1'b0;
         width_order.delete();
         height_order.delete();
         o.status = srpf_pkg::ST_CLEARED;
      end
      o.count = 6'(width_order.size());
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   // drive one transaction and hold until accepted; valid stays up for the next
   task automatic send_req(pool_req_type r, logic typed, pool_rsp_type want);
      pool_rsp_type p;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      p = pool_apply(r);
      if (typed && p != want) report_mismatch("table row", 32'(p), 32'(want));
      expected_rsps.push_back(p);
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_width <= r.w;
      req_height <= r.h;
      req_min_filter_code <= r.fmin;
      req_mag_filter_code <= r.fmag;
      req_force_new <= r.force_new;
      req_entry_handle <= r.handle;
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_status), 32'd0);
            end else begin
               pool_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_status != e.status)
                  report_mismatch("status", 32'(rsp_status), 32'(e.status));
               if (rsp_out_handle != e.handle)
                  report_mismatch("out_handle", rsp_out_handle, e.handle);
               if (rsp_pool_count != e.count)
                  report_mismatch("pool_count", 32'(rsp_pool_count), 32'(e.count));
               case (e.status)
                  srpf_pkg::ST_HIT:    hits++;
                  srpf_pkg::ST_MISS:   misses++;
                  srpf_pkg::ST_FULL:   fulls++;
                  srpf_pkg::ST_STORED: stores++;
                  default: ;
               endcase
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) watchdog <= 0;
         else watchdog <= watchdog + 1;
         if (watchdog >= WatchMax && !timed_out) begin
            timed_out <= 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic pool_req_type mk(srpf_pkg::opcode_type op, int w, int h, int fmin,
                                       int fmag, logic f, logic [31:0] hd);
      pool_req_type r;
      r.op = op; r.w = 15'(w); r.h = 15'(h); r.fmin = 16'(fmin); r.fmag = 16'(fmag);
      r.force_new = f; r.handle = hd;
      return r;
   endfunction

   function automatic pool_rsp_type rs(srpf_pkg::status_type s, logic [31:0] hd, int c);
      pool_rsp_type o;
      o.status = s; o.handle = hd; o.count = 6'(c);
      return o;
   endfunction

   // random request, mostly well-formed put/get mixes over few filter codes
   function automatic pool_req_type rand_req();
      pool_req_type r;
      int k;
      k = $urandom_range(99);
      r.op = (k < 45) ? srpf_pkg::OP_PUT : (k < 92) ? srpf_pkg::OP_GET :
             (k < 96) ? srpf_pkg::OP_CLEAR : srpf_pkg::OP_NONE;
      if ($urandom_range(9) == 0) begin
         r.w = 15'($urandom);  r.h = 15'($urandom);
         r.fmin = 16'($urandom);  r.fmag = 16'($urandom);
      end else begin
         r.w = 15'($urandom_range(64));  r.h = 15'($urandom_range(64));
         r.fmin = 16'($urandom_range(1));  r.fmag = 16'($urandom_range(1) ? 16'hffff : 0);
      end
      r.force_new = ($urandom_range(9) == 0);
      r.handle = $urandom;
      return r;
   endfunction

   table_row_type dir_rows[$];

   initial begin
      pool_rsp_type z;
      z = '0;
      dir_rows = '{
         '{mk(srpf_pkg::OP_GET, 0, 0, 0, 0, 0, 0), 1, rs(srpf_pkg::ST_MISS, 0, 0)},
         '{mk(srpf_pkg::OP_PUT, 16384, 16384, 65535, 65535, 1, 32'hffffffff), 1,
           rs(srpf_pkg::ST_STORED, 0, 1)},
         '{mk(srpf_pkg::OP_PUT, 0, 0, 0, 0, 0, 32'h0), 1, rs(srpf_pkg::ST_STORED, 0, 2)},
         '{mk(srpf_pkg::OP_PUT, 32767, 1, 7, 9, 0, 32'h5a5a5a5a), 1,
           rs(srpf_pkg::ST_STORED, 0, 3)},
         '{mk(srpf_pkg::OP_PUT, 10, 20, 1, 2, 0, 32'h11), 1, rs(srpf_pkg::ST_STORED, 0, 4)},
         '{mk(srpf_pkg::OP_PUT, 10, 20, 1, 2, 0, 32'h12), 1, rs(srpf_pkg::ST_STORED, 0, 5)},
         '{mk(srpf_pkg::OP_GET, 10, 20, 1, 2, 1, 0), 1, rs(srpf_pkg::ST_MISS, 0, 5)},
         '{mk(srpf_pkg::OP_GET, 10, 20, 1, 2, 0, 0), 1, rs(srpf_pkg::ST_HIT, 32'h11, 4)},
         '{mk(srpf_pkg::OP_GET, 5, 5, 1, 3, 0, 0), 1, rs(srpf_pkg::ST_MISS, 0, 4)},
         '{mk(srpf_pkg::OP_GET, 16384, 16384, 65535, 65535, 0, 0), 1,
           rs(srpf_pkg::ST_HIT, 32'hffffffff, 3)},
         '{mk(srpf_pkg::OP_NONE, 1, 1, 0, 0, 1, 32'h33), 1, rs(srpf_pkg::ST_MISS, 0, 3)},
         '{mk(srpf_pkg::OP_GET, 32767, 0, 7, 9, 0, 0), 0, z},
         '{mk(srpf_pkg::OP_GET, 0, 0, 0, 0, 0, 0), 0, z},
         '{mk(srpf_pkg::OP_CLEAR, 3, 3, 3, 3, 1, 32'h44), 1, rs(srpf_pkg::ST_CLEARED, 0, 0)},
         '{mk(srpf_pkg::OP_GET, 1, 2, 1, 2, 0, 0), 1, rs(srpf_pkg::ST_MISS, 0, 0)}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (m_valid[i]) m_valid[i] = 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      // fill past capacity: pool full rejection
      for (int i = 0; i < Depth + 2; i++)
         send_req(mk(srpf_pkg::OP_PUT, $urandom_range(40), $urandom_range(40), 0, 0, 0,
                     $urandom), 0, z);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 37 : (ph == 1) ? 57 : 0;
         recv_idle = (ph == 0) ? 57 : (ph == 1) ? 37 : 0;
         for (int n = 0; n < 200; n++) begin
            send_req(rand_req(), 0, z);
            // hold off until the pool has drained its results
            if (n == 100) begin
               req_valid <= 1'b0;
               while (expected_rsps.size() != 0) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (2 * Depth + 10) @(posedge clock);
      $display("ran %0d directed and 600 random transactions: %0d stores, %0d hits,",
               dir_rows.size() + Depth + 2, stores, hits);
      $display("%0d misses, %0d full rejections, across three idle patterns", misses, fulls);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
